// ===== rtl/fdtd_pkg.sv =====
// Shared types and constants for the Yee-grid FDTD time step core.
// Used by the field RAM, the update unit and the top level; no dependencies.
package fdtd_pkg;

    localparam int MAX_DIM  = 16;
    localparam int DIM_W    = $clog2(MAX_DIM);
    localparam int ADDR_W   = 3 * DIM_W;
    localparam int CELLS    = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int FIELD_W  = 32;
    localparam int COEF_W   = 48;
    localparam int SCALE_W  = 32;
    localparam int SIZE_W   = 5;
    localparam int ACC_W    = 52;
    localparam int NUM_MEM  = 6;

    localparam int M_EX = 0;
    localparam int M_EY = 1;
    localparam int M_EZ = 2;
    localparam int M_HX = 3;
    localparam int M_HY = 4;
    localparam int M_HZ = 5;

    localparam logic [2:0] CFG_E_COEFF  = 3'd0;
    localparam logic [2:0] CFG_H_COEFF  = 3'd1;
    localparam logic [2:0] CFG_SRC_SCL  = 3'd2;
    localparam logic [2:0] CFG_SIZE_X   = 3'd3;
    localparam logic [2:0] CFG_SIZE_Y   = 3'd4;
    localparam logic [2:0] CFG_SIZE_Z   = 3'd5;
    localparam logic [2:0] CFG_PROBE_X  = 3'd6;
    localparam logic [2:0] CFG_PROBE_Y  = 3'd7;

    typedef logic signed [FIELD_W-1:0] t_field;

    typedef struct packed {
        logic                start;
        t_field              old;
        logic [COEF_W-1:0]   coef;
        t_field              a;
        t_field              b;
        t_field              c;
        t_field              d;
    } t_upd_req;

    typedef struct packed {
        logic   done;
        logic   ovf;
        t_field result;
    } t_upd_rsp;

    typedef enum logic [2:0] {
        U_IDLE, U_DIFF, U_MUL0, U_MUL1, U_ACC, U_SAT
    } t_ust;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_UPD_GO, ST_UPD_WAIT, ST_WR, ST_WALL,
        ST_PROBE_RD, ST_PROBE_CAP
    } t_state;

    typedef enum logic [1:0] {
        PASS_E, PASS_WALL, PASS_SRC, PASS_H
    } t_pass;

endpackage

// ===== rtl/fdtd_ram.sv =====
// One field memory: one write port and one read port with registered data.
// Depends on fdtd_pkg for depth and width.
module fdtd_ram
    import fdtd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_field            i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_field            o_rdata
);

    t_field r_mem [CELLS];
    t_field r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fdtd_upd.sv =====
// Field update unit: old + coef*(a-b) - coef*(c-d), truncated and saturated.
// Uses one shared 32x32 multiplier over several cycles; depends on fdtd_pkg.
module fdtd_upd
    import fdtd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_upd_req i_req,
    output t_upd_rsp o_rsp
);

    t_ust                       r_st, n_st;
    logic                       r_ph;
    logic [COEF_W-1:0]          r_coef;
    t_field                     r_a, r_b, r_c, r_d;
    logic signed [ACC_W-1:0]    r_acc;
    logic [FIELD_W-1:0]         r_mag;
    logic                       r_neg;
    logic [63:0]                r_p0;
    logic [47:0]                r_p1;

    logic signed [FIELD_W:0]    diff;
    logic [31:0]                mul_b;
    logic [63:0]                mul_p;
    logic [79:0]                prod;
    logic signed [ACC_W-1:0]    term;
    logic                       fits;

    always_comb begin
        n_st = r_st;
        case (r_st)
            U_IDLE: if (i_req.start) n_st = U_DIFF;
            U_DIFF: n_st = U_MUL0;
            U_MUL0: n_st = U_MUL1;
            U_MUL1: n_st = U_ACC;
            U_ACC:  n_st = r_ph ? U_SAT : U_DIFF;
            U_SAT:  n_st = U_IDLE;
            default: n_st = U_IDLE;
        endcase
    end

    always_comb begin
        diff = r_ph ? ({r_c[FIELD_W-1], r_c} - {r_d[FIELD_W-1], r_d})
                    : ({r_a[FIELD_W-1], r_a} - {r_b[FIELD_W-1], r_b});
        mul_b = (r_st == U_MUL1) ? {16'd0, r_coef[COEF_W-1:32]} : r_coef[31:0];
        mul_p = {32'd0, r_mag} * {32'd0, mul_b};
        prod = {16'd0, r_p0} + {r_p1, 32'd0};
        term = (r_neg ^ r_ph) ? -$signed({4'd0, prod[79:32]})
                              : $signed({4'd0, prod[79:32]});
        fits = (r_acc[ACC_W-1:FIELD_W-1] == '0) || (r_acc[ACC_W-1:FIELD_W-1] == '1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= U_IDLE;
            r_ph <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == U_IDLE) begin
                r_ph <= 1'b0;
            end else if (r_st == U_ACC) begin
                r_ph <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            U_IDLE: begin
                r_coef <= i_req.coef;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_c    <= i_req.c;
                r_d    <= i_req.d;
                r_acc  <= ACC_W'(i_req.old);
            end
            U_DIFF: begin
                r_neg <= diff[FIELD_W];
                r_mag <= diff[FIELD_W] ? FIELD_W'(-diff) : diff[FIELD_W-1:0];
            end
            U_MUL0: r_p0 <= mul_p;
            U_MUL1: r_p1 <= mul_p[47:0];
            U_ACC:  r_acc <= r_acc + term;
            default: ;
        endcase
    end

    always_comb begin
        o_rsp.done = (r_st == U_SAT);
        o_rsp.ovf  = (r_st == U_SAT) && !fits;
        if (fits) begin
            o_rsp.result = r_acc[FIELD_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            o_rsp.result = {1'b1, {(FIELD_W-1){1'b0}}};
        end else begin
            o_rsp.result = {1'b0, {(FIELD_W-1){1'b1}}};
        end
    end

endmodule

// ===== rtl/fdtd_yee_grid_time_step_core.sv =====
// Yee-grid FDTD time step core: six field RAMs, a cell sequencer and one update unit.
// Each step accepts one beat, then runs an E pass over the interior cells, a wall pass at
// one grid cell per cycle, a source pass, an H pass and a probe read; the shared multiplier
// in the update unit paces the E, H and source passes. One step at a time.
// After reset, and before a step with restart set, a clearing pass zeroes every cell of
// the field RAMs; no beat is accepted during it. Depends on fdtd_pkg, fdtd_ram, fdtd_upd.
module fdtd_yee_grid_time_step_core
    import fdtd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // source_value
    input  logic              s_axis_tuser,   // restart
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // probe_value
    output logic              m_axis_tuser,   // overflow
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [COEF_W-1:0] i_cfg_data
);

    t_state               r_state, n_state;
    t_pass                r_pass;
    logic [ADDR_W-1:0]    r_clr;
    logic                 r_go;
    logic [DIM_W-1:0]     r_i, r_j, r_k;
    logic [1:0]           r_slot;
    logic [1:0]           r_comp;
    t_field               r_src;
    logic                 r_ovf;
    t_field               r_res [3];
    t_field               r_rd [NUM_MEM][3];
    t_field               r_probe;
    logic                 r_out_valid;
    logic                 r_out_ovf;

    logic [COEF_W-1:0]    r_e_coeff, r_h_coeff;
    logic [SCALE_W-1:0]   r_src_scale;
    logic [SIZE_W-1:0]    r_size_x, r_size_y, r_size_z;
    logic [DIM_W-1:0]     r_probe_x, r_probe_y;

    logic                 mem_we    [NUM_MEM];
    logic [ADDR_W-1:0]    mem_waddr [NUM_MEM];
    t_field               mem_wdata [NUM_MEM];
    logic [ADDR_W-1:0]    mem_raddr [NUM_MEM];
    t_field               mem_rdata [NUM_MEM];

    t_upd_req             upd_req;
    t_upd_rsp             upd_rsp;

    logic [SIZE_W-1:0]    nx, ny, nz;
    logic [DIM_W-1:0]     i_hi, j_lo, j_hi, k_lo, k_hi;
    logic                 last_cell;
    logic [ADDR_W-1:0]    cur_addr, nb_i, nb_j, nb_k, ad_x, ad_y, ad_z, probe_addr;
    logic [DIM_W-1:0]     ip, jp, kp;
    logic                 s_acc;

    function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_W-1:0] r);
        if (r < SIZE_W'(6)) begin
            return SIZE_W'(6);
        end else if (r > SIZE_W'(MAX_DIM)) begin
            return SIZE_W'(MAX_DIM);
        end
        return r;
    endfunction

    assign nx = clamp_dim(r_size_x);
    assign ny = clamp_dim(r_size_y);
    assign nz = clamp_dim(r_size_z);

    always_comb begin
        j_lo = DIM_W'(1);
        k_lo = DIM_W'(1);
        i_hi = DIM_W'(nx - SIZE_W'(2));
        j_hi = DIM_W'(ny - SIZE_W'(2));
        k_hi = DIM_W'(nz - SIZE_W'(2));
        case (r_pass)
            PASS_WALL: begin
                j_lo = '0;
                k_lo = '0;
                i_hi = DIM_W'(nx - SIZE_W'(1));
                j_hi = DIM_W'(ny - SIZE_W'(1));
                k_hi = DIM_W'(nz - SIZE_W'(1));
            end
            PASS_SRC: begin
                i_hi = DIM_W'(2);
            end
            default: ;
        endcase
        last_cell = (r_i == i_hi) && (r_j == j_hi) && (r_k == k_hi);
    end

    always_comb begin
        cur_addr = {r_i, r_j, r_k};
        ip   = (r_pass == PASS_H) ? r_i + DIM_W'(1) : r_i - DIM_W'(1);
        jp   = (r_pass == PASS_H) ? r_j + DIM_W'(1) : r_j - DIM_W'(1);
        kp   = (r_pass == PASS_H) ? r_k + DIM_W'(1) : r_k - DIM_W'(1);
        nb_i = {ip, r_j, r_k};
        nb_j = {r_i, jp, r_k};
        nb_k = {r_i, r_j, kp};
        case (r_slot)
            2'd1: begin
                ad_x = nb_k;
                ad_y = nb_k;
                ad_z = nb_j;
            end
            2'd2: begin
                ad_x = nb_j;
                ad_y = nb_i;
                ad_z = nb_i;
            end
            default: begin
                ad_x = cur_addr;
                ad_y = cur_addr;
                ad_z = cur_addr;
            end
        endcase
        probe_addr = {r_probe_x, r_probe_y, nz[DIM_W:1]};
    end

    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_probe;
    assign m_axis_tuser  = r_out_ovf;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = r_go ? ST_READ : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    n_state = s_axis_tuser ? ST_CLEAR : ST_READ;
                end
            end
            ST_READ: if (r_slot == 2'd3) n_state = ST_UPD_GO;
            ST_UPD_GO: n_state = ST_UPD_WAIT;
            ST_UPD_WAIT: begin
                if (upd_rsp.done) begin
                    n_state = (r_comp == 2'd2 || r_pass == PASS_SRC) ? ST_WR : ST_UPD_GO;
                end
            end
            ST_WR: begin
                if (!last_cell) begin
                    n_state = (r_pass == PASS_SRC) ? ST_UPD_GO : ST_READ;
                end else begin
                    case (r_pass)
                        PASS_E:   n_state = ST_WALL;
                        PASS_SRC: n_state = ST_READ;
                        default:  n_state = ST_PROBE_RD;
                    endcase
                end
            end
            ST_WALL: if (last_cell) n_state = ST_UPD_GO;
            ST_PROBE_RD: n_state = ST_PROBE_CAP;
            ST_PROBE_CAP: if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        for (int m = 0; m < NUM_MEM; m++) begin
            mem_we[m]    = 1'b0;
            mem_waddr[m] = cur_addr;
            mem_wdata[m] = '0;
            mem_raddr[m] = cur_addr;
        end
        if (r_pass == PASS_E) begin
            mem_raddr[M_HX] = ad_x;
            mem_raddr[M_HY] = ad_y;
            mem_raddr[M_HZ] = ad_z;
        end else begin
            mem_raddr[M_EX] = ad_x;
            mem_raddr[M_EY] = ad_y;
            mem_raddr[M_EZ] = ad_z;
        end
        case (r_state)
            ST_CLEAR: begin
                for (int m = 0; m < NUM_MEM; m++) begin
                    mem_we[m]    = 1'b1;
                    mem_waddr[m] = r_clr;
                end
            end
            ST_WALL: begin
                mem_we[M_EX] = (r_k == DIM_W'(1));
                mem_we[M_EY] = (r_k == DIM_W'(1)) || (r_i == DIM_W'(1));
                mem_we[M_EZ] = (r_i == DIM_W'(1));
            end
            ST_WR: begin
                case (r_pass)
                    PASS_E: begin
                        for (int m = 0; m < 3; m++) begin
                            mem_we[M_EX + m]    = 1'b1;
                            mem_wdata[M_EX + m] = r_res[m];
                        end
                    end
                    PASS_H: begin
                        for (int m = 0; m < 3; m++) begin
                            mem_we[M_HX + m]    = 1'b1;
                            mem_wdata[M_HX + m] = r_res[m];
                        end
                    end
                    PASS_SRC: begin
                        mem_we[M_EZ]    = 1'b1;
                        mem_wdata[M_EZ] = r_src;
                        mem_we[M_HX]    = 1'b1;
                        mem_wdata[M_HX] = r_res[0];
                    end
                    default: ;
                endcase
            end
            ST_PROBE_RD, ST_PROBE_CAP: mem_raddr[M_EZ] = probe_addr;
            default: ;
        endcase
    end

    always_comb begin
        upd_req.start = (r_state == ST_UPD_GO);
        upd_req.coef  = (r_pass == PASS_H) ? r_h_coeff : r_e_coeff;
        upd_req.old   = '0;
        upd_req.a     = '0;
        upd_req.b     = '0;
        upd_req.c     = '0;
        upd_req.d     = '0;
        case (r_pass)
            PASS_E: begin
                case (r_comp)
                    2'd0: begin
                        upd_req.old = r_rd[M_EX][0];
                        upd_req.a = r_rd[M_HZ][0];
                        upd_req.b = r_rd[M_HZ][1];
                        upd_req.c = r_rd[M_HY][0];
                        upd_req.d = r_rd[M_HY][1];
                    end
                    2'd1: begin
                        upd_req.old = r_rd[M_EY][0];
                        upd_req.a = r_rd[M_HX][0];
                        upd_req.b = r_rd[M_HX][1];
                        upd_req.c = r_rd[M_HZ][0];
                        upd_req.d = r_rd[M_HZ][2];
                    end
                    default: begin
                        upd_req.old = r_rd[M_EZ][0];
                        upd_req.a = r_rd[M_HY][0];
                        upd_req.b = r_rd[M_HY][2];
                        upd_req.c = r_rd[M_HX][0];
                        upd_req.d = r_rd[M_HX][2];
                    end
                endcase
            end
            PASS_H: begin
                case (r_comp)
                    2'd0: begin
                        upd_req.old = r_rd[M_HX][0];
                        upd_req.a = r_rd[M_EY][1];
                        upd_req.b = r_rd[M_EY][0];
                        upd_req.c = r_rd[M_EZ][1];
                        upd_req.d = r_rd[M_EZ][0];
                    end
                    2'd1: begin
                        upd_req.old = r_rd[M_HY][0];
                        upd_req.a = r_rd[M_EZ][2];
                        upd_req.b = r_rd[M_EZ][0];
                        upd_req.c = r_rd[M_EX][1];
                        upd_req.d = r_rd[M_EX][0];
                    end
                    default: begin
                        upd_req.old = r_rd[M_HZ][0];
                        upd_req.a = r_rd[M_EX][2];
                        upd_req.b = r_rd[M_EX][0];
                        upd_req.c = r_rd[M_EY][2];
                        upd_req.d = r_rd[M_EY][0];
                    end
                endcase
            end
            default: begin
                upd_req.coef = {{(COEF_W-SCALE_W){1'b0}}, r_src_scale};
                upd_req.a    = r_src;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_pass      <= PASS_E;
            r_clr       <= '0;
            r_go        <= 1'b0;
            r_i         <= DIM_W'(1);
            r_j         <= DIM_W'(1);
            r_k         <= DIM_W'(1);
            r_slot      <= '0;
            r_comp      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_e_coeff   <= COEF_W'(64'd208371025560);
            r_h_coeff   <= COEF_W'(64'd1468149);
            r_src_scale <= SCALE_W'(32'd11400653);
            r_size_x    <= SIZE_W'(16);
            r_size_y    <= SIZE_W'(16);
            r_size_z    <= SIZE_W'(16);
            r_probe_x   <= DIM_W'(4);
            r_probe_y   <= DIM_W'(1);
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_E_COEFF: r_e_coeff   <= i_cfg_data;
                    CFG_H_COEFF: r_h_coeff   <= i_cfg_data;
                    CFG_SRC_SCL: r_src_scale <= i_cfg_data[SCALE_W-1:0];
                    CFG_SIZE_X:  r_size_x    <= i_cfg_data[SIZE_W-1:0];
                    CFG_SIZE_Y:  r_size_y    <= i_cfg_data[SIZE_W-1:0];
                    CFG_SIZE_Z:  r_size_z    <= i_cfg_data[SIZE_W-1:0];
                    CFG_PROBE_X: r_probe_x   <= i_cfg_data[DIM_W-1:0];
                    CFG_PROBE_Y: r_probe_y   <= i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_PROBE_CAP && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: r_clr <= r_clr + ADDR_W'(1);
                ST_IDLE: begin
                    if (s_acc) begin
                        r_go   <= 1'b1;
                        r_ovf  <= 1'b0;
                        r_pass <= PASS_E;
                        r_i    <= DIM_W'(1);
                        r_j    <= DIM_W'(1);
                        r_k    <= DIM_W'(1);
                        r_slot <= '0;
                    end
                end
                ST_READ: r_slot <= r_slot + 2'd1;
                ST_UPD_WAIT: begin
                    if (upd_rsp.done) begin
                        r_ovf  <= r_ovf | upd_rsp.ovf;
                        r_comp <= r_comp + 2'd1;
                    end
                end
                ST_WR, ST_WALL: begin
                    r_slot <= '0;
                    r_comp <= '0;
                    if (!last_cell) begin
                        if (r_k != k_hi) begin
                            r_k <= r_k + DIM_W'(1);
                        end else begin
                            r_k <= k_lo;
                            if (r_j != j_hi) begin
                                r_j <= r_j + DIM_W'(1);
                            end else begin
                                r_j <= j_lo;
                                r_i <= r_i + DIM_W'(1);
                            end
                        end
                    end else begin
                        case (r_pass)
                            PASS_E: begin
                                r_pass <= PASS_WALL;
                                r_i    <= '0;
                                r_j    <= '0;
                                r_k    <= '0;
                            end
                            PASS_WALL: begin
                                r_pass <= PASS_SRC;
                                r_i    <= DIM_W'(2);
                                r_j    <= DIM_W'(1);
                                r_k    <= DIM_W'(1);
                            end
                            PASS_SRC: begin
                                r_pass <= PASS_H;
                                r_i    <= DIM_W'(1);
                                r_j    <= DIM_W'(1);
                                r_k    <= DIM_W'(1);
                            end
                            default: r_go <= 1'b0;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_src <= s_axis_tdata;
        end
        if (r_state == ST_READ && r_slot != 2'd0) begin
            for (int m = 0; m < NUM_MEM; m++) begin
                r_rd[m][r_slot - 2'd1] <= mem_rdata[m];
            end
        end
        if (r_state == ST_UPD_WAIT && upd_rsp.done) begin
            r_res[r_comp] <= upd_rsp.result;
        end
        if (r_state == ST_PROBE_CAP && (!r_out_valid || m_axis_tready)) begin
            r_probe   <= mem_rdata[M_EZ];
            r_out_ovf <= r_ovf;
        end
    end

    for (genvar g = 0; g < NUM_MEM; g++) begin : g_mem
        fdtd_ram u_ram (
            .i_clk   (i_clk),
            .i_we    (mem_we[g]),
            .i_waddr (mem_waddr[g]),
            .i_wdata (mem_wdata[g]),
            .i_raddr (mem_raddr[g]),
            .o_rdata (mem_rdata[g])
        );
    end

    fdtd_upd u_upd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (upd_req),
        .o_rsp   (upd_rsp)
    );

endmodule
